[src/cascaded_position_speed_pid_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the cascaded position and speed loop
// Each macro expands to a labelled concurrent assertion, or to nothing.
// ---------------------------------------------------------------------------
`ifndef CASCADED_POSITION_SPEED_PID_DEFINES_SVH
`define CASCADED_POSITION_SPEED_PID_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Implication checked at every clock edge outside reset.
`define CPSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CPSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CPSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define CPSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[src/cpsp_pkg.sv]
// ---------------------------------------------------------------------------
// Cascaded position and speed loop package
// Payload types, register indexes, limits and the controller interface.
// ---------------------------------------------------------------------------
package cpsp_pkg;

   localparam int IntegralLimit = 1000;
   localparam int PosOutLimit   = 10;
   localparam int SpeedOutLimit = 100;
   localparam logic [15:0] LpfNew = 16'd19661;
   localparam logic [15:0] LpfOld = 16'd45875;

   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_SCALE  = 3'd1;
   localparam logic [2:0] REG_POS_KP = 3'd2;
   localparam logic [2:0] REG_POS_KI = 3'd3;
   localparam logic [2:0] REG_POS_KD = 3'd4;
   localparam logic [2:0] REG_SPD_KP = 3'd5;
   localparam logic [2:0] REG_SPD_KI = 3'd6;
   localparam logic [2:0] REG_SPD_KD = 3'd7;

   typedef struct packed {
      logic signed [15:0] count_delta;
      logic signed [31:0] position_target;
      logic signed [23:0] speed_target;
   } req_type;

   typedef struct packed {
      logic signed [7:0]  duty;
      logic signed [31:0] speed_rps;
      logic signed [31:0] position_count;
      logic signed [23:0] speed_command;
   } rsp_type;

   // Datapath step codes issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_RAW,
      OP_LPF_NEW,
      OP_LPF_OLD,
      OP_POS_KP,
      OP_POS_KI,
      OP_POS_KD,
      OP_SPD_ERR,
      OP_SPD_KP,
      OP_SPD_KI,
      OP_SPD_KD,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

endpackage

[src/cascaded_position_speed_pid.sv]
// The response beat becomes valid once the response register is loaded at the end of the step sequence.
// A new request beat is taken only after the previous tick has run its sequence through the shared multiplier.
// The response register frees the datapath while a result waits downstream;
// a finished tick waits while that register is still full and stalled.
// Reset (synchronous, active high) restores register defaults, clears loop state.
// ---------------------------------------------------------------------------
// Cascaded position and speed loop, top level
// Joins the controller, datapath and response register.
// ---------------------------------------------------------------------------
`include "cascaded_position_speed_pid_defines.svh"
module cascaded_position_speed_pid (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  cpsp_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cpsp_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data
);
   import cpsp_pkg::*;

   cmd_type cmd;
   rsp_type result;
   rsp_type rsp_ff;
   logic    rsp_load;

   assign csr_ready = 1'b1;

   cpsp_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_load(rsp_load), .cmd(cmd)
   );

   cpsp_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_data(req_data),
      .cfg_we(csr_valid), .cfg_index(csr_index), .cfg_value(csr_data),
      .result(result)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (rsp_load) rsp_ff <= result;
   end
   assign rsp_data = rsp_ff;

   `CPSP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request accepted while busy")
   `CPSP_ASSERT_NEXT(a_valid_after_load, clock, reset, rsp_load, rsp_valid, "response lost after load")
   `CPSP_ASSERT_IMPL(a_no_load_when_full, clock, reset, rsp_load && rsp_valid, !rsp_stall, "response overwritten")

endmodule

[src/cpsp_datapath.sv]
// ---------------------------------------------------------------------------
// Cascaded loop datapath
// Loop state, register file and one shared 34x25 signed multiplier.
// ---------------------------------------------------------------------------
module cpsp_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  cpsp_pkg::cmd_type    cmd,
   input  cpsp_pkg::req_type    req_data,
   input  logic                 cfg_we,
   input  logic [2:0]           cfg_index,
   input  logic [23:0]          cfg_value,
   output cpsp_pkg::rsp_type    result
);
   import cpsp_pkg::*;

   localparam logic signed [63:0] PosLim = 64'(PosOutLimit) <<< 16;
   localparam logic signed [63:0] IntLim = 64'(IntegralLimit);
   localparam logic signed [63:0] SIntLim = 64'(IntegralLimit) <<< 16;
   localparam logic signed [63:0] SpdLim = 64'(SpeedOutLimit) <<< 32;

   logic [3:0]          mode_ff;
   logic [23:0]         scale_ff;
   logic signed [23:0]  pkp_ff, pki_ff, pkd_ff, skp_ff, ski_ff, skd_ff;

   logic signed [31:0]  pos_ff, filt_ff, pint_ff, pprev_ff, sint_ff, sprev_ff;
   logic signed [16:0]  delta_ff;
   logic signed [31:0]  ptarget_ff, raw_ff;
   logic signed [23:0]  starget_ff, cmd_ff;
   logic signed [33:0]  perr_ff, pder_ff, pinteg_ff;
   logic signed [33:0]  serr_ff, sder_ff, sinteg_ff;
   logic signed [63:0]  acc_ff;
   logic signed [7:0]   duty_ff;

   logic signed [33:0]  mul_a;
   logic signed [24:0]  mul_b;
   logic signed [58:0]  prod;
   logic signed [63:0]  acc_sum;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 4'd1;
         scale_ff <= 24'd22918;
         pkp_ff   <= 24'sd393;
         pki_ff   <= 24'sd0;
         pkd_ff   <= 24'sd10813;
         skp_ff   <= 24'sd117965;
         ski_ff   <= 24'sd7209;
         skd_ff   <= 24'sd983;
      end else if (cfg_we) begin
         case (cfg_index)
            REG_MODE:   mode_ff  <= cfg_value[3:0];
            REG_SCALE:  scale_ff <= cfg_value;
            REG_POS_KP: pkp_ff   <= cfg_value;
            REG_POS_KI: pki_ff   <= cfg_value;
            REG_POS_KD: pkd_ff   <= cfg_value;
            REG_SPD_KP: skp_ff   <= cfg_value;
            REG_SPD_KI: ski_ff   <= cfg_value;
            REG_SPD_KD: skd_ff   <= cfg_value;
            default:    ;
         endcase
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_RAW:     begin mul_a = 34'(delta_ff);  mul_b = 25'($signed({1'b0, scale_ff})); end
         OP_LPF_NEW: begin mul_a = 34'(raw_ff);    mul_b = 25'($signed({1'b0, LpfNew}));   end
         OP_LPF_OLD: begin mul_a = 34'(filt_ff);   mul_b = 25'($signed({1'b0, LpfOld}));   end
         OP_POS_KP:  begin mul_a = perr_ff;        mul_b = 25'(pkp_ff); end
         OP_POS_KI:  begin mul_a = pinteg_ff;      mul_b = 25'(pki_ff); end
         OP_POS_KD:  begin mul_a = pder_ff;        mul_b = 25'(pkd_ff); end
         OP_SPD_KP:  begin mul_a = serr_ff;        mul_b = 25'(skp_ff); end
         OP_SPD_KI:  begin mul_a = sinteg_ff;      mul_b = 25'(ski_ff); end
         OP_SPD_KD:  begin mul_a = sder_ff;        mul_b = 25'(skd_ff); end
         default:    ;
      endcase
   end

   assign prod    = 59'(mul_a) * 59'(mul_b);
   assign acc_sum = acc_ff + 64'(prod);

   // Helpers for saturation and clamping.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (x < -64'sh80000000) return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic logic signed [63:0] clamp(input logic signed [63:0] x,
                                                 input logic signed [63:0] lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
   endfunction

   // Sequenced datapath steps.
   always_ff @(posedge clock) begin
      logic signed [63:0] t;
      logic signed [63:0] m;
      logic signed [31:0] npos;
      logic signed [31:0] nfilt;
      if (reset) begin
         pos_ff   <= '0;
         filt_ff  <= '0;
         pint_ff  <= '0;
         pprev_ff <= '0;
         sint_ff  <= '0;
         sprev_ff <= '0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               delta_ff   <= mode_ff[2] ? -17'(req_data.count_delta)
                                        : 17'(req_data.count_delta);
               ptarget_ff <= req_data.position_target;
               starget_ff <= req_data.speed_target;
               acc_ff     <= '0;
            end
            OP_RAW: begin
               raw_ff <= sat32(64'(prod));
               npos = sat32(64'(pos_ff) + 64'(delta_ff));
               pos_ff <= npos;
            end
            OP_LPF_NEW: begin
               acc_ff <= 64'sd32768 + 64'(prod);
               // Position PID terms use the updated count.
               perr_ff <= 34'(ptarget_ff) - 34'(pos_ff);
               pder_ff <= 34'(pprev_ff) - 34'(pos_ff);
               pinteg_ff <= 34'(clamp(64'(pint_ff) + 64'(ptarget_ff) - 64'(pos_ff), IntLim));
            end
            OP_LPF_OLD: begin
               t = acc_sum >>> 16;
               nfilt = t[31:0];
               filt_ff <= nfilt;
               acc_ff  <= '0;
               if (mode_ff[0]) begin
                  pint_ff  <= pinteg_ff[31:0];
                  pprev_ff <= pos_ff;
               end
            end
            OP_POS_KP, OP_POS_KI: acc_ff <= acc_sum;
            OP_POS_KD: begin
               t = clamp(acc_sum, PosLim);
               cmd_ff <= mode_ff[0] ? t[23:0] : starget_ff;
               acc_ff <= '0;
            end
            // Speed PID terms from the registered speed command.
            OP_SPD_ERR: begin
               serr_ff   <= 34'(cmd_ff) - 34'(filt_ff);
               sder_ff   <= 34'(sprev_ff) - 34'(filt_ff);
               sinteg_ff <= 34'(clamp(64'(sint_ff) + 64'(cmd_ff) - 64'(filt_ff), SIntLim));
            end
            OP_SPD_KP, OP_SPD_KI: acc_ff <= acc_sum;
            OP_SPD_KD: begin
               acc_ff <= clamp(acc_sum, SpdLim);
               if (!mode_ff[1]) begin
                  sint_ff  <= sinteg_ff[31:0];
                  sprev_ff <= filt_ff;
               end
            end
            OP_FINISH: begin
               m = acc_ff[63] ? -acc_ff : acc_ff;
               m = (m + (64'sd1 <<< 31)) >>> 32;
               t = acc_ff[63] ? -m : m;
               if (mode_ff[1]) t = '0;
               if (mode_ff[3]) t = -t;
               duty_ff <= t[7:0];
            end
            default: ;
         endcase
      end
   end

   assign result.duty           = duty_ff;
   assign result.speed_rps      = filt_ff;
   assign result.position_count = pos_ff;
   assign result.speed_command  = cmd_ff;

endmodule

[src/cpsp_controller.sv]
// ---------------------------------------------------------------------------
// Cascaded loop controller
// Sequences one tick through the datapath and runs the result register.
// ---------------------------------------------------------------------------
module cpsp_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_load,
   output cpsp_pkg::cmd_type  cmd
);
   import cpsp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RAW, S_LNEW, S_LOLD, S_PKP, S_PKI, S_PKD, S_SERR,
      S_SKP, S_SKI, S_SKD, S_FIN, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   // A new beat is taken only when idle; the result register may still be full.
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: if (req_valid) begin cmd.op = OP_LOAD; state_in = S_RAW; end
         S_RAW:  begin cmd.op = OP_RAW;     state_in = S_LNEW; end
         S_LNEW: begin cmd.op = OP_LPF_NEW; state_in = S_LOLD; end
         S_LOLD: begin cmd.op = OP_LPF_OLD; state_in = S_PKP;  end
         S_PKP:  begin cmd.op = OP_POS_KP;  state_in = S_PKI;  end
         S_PKI:  begin cmd.op = OP_POS_KI;  state_in = S_PKD;  end
         S_PKD:  begin cmd.op = OP_POS_KD;  state_in = S_SERR; end
         S_SERR: begin cmd.op = OP_SPD_ERR; state_in = S_SKP;  end
         S_SKP:  begin cmd.op = OP_SPD_KP;  state_in = S_SKI;  end
         S_SKI:  begin cmd.op = OP_SPD_KI;  state_in = S_SKD;  end
         S_SKD:  begin cmd.op = OP_SPD_KD;  state_in = S_FIN;  end
         S_FIN:  begin cmd.op = OP_FINISH;  state_in = S_OUT;  end
         S_OUT:  if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // State and result-valid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

endmodule
